// File: rtl/epes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epes_pkg
// Shared widths, codes, genotype dosage decode and the controller/datapath
// command and status words of the epistasis pair effect scan.
// ----------------------------------------------------------------------------
package epes_pkg;

   localparam int unsigned DefaultMaxMarkers = 65536;

   localparam int unsigned SnpWidth    = 16;
   localparam int unsigned FreqWidth   = 17;
   localparam int unsigned WeightWidth = 32;
   localparam int unsigned ThrWidth    = 48;
   localparam int unsigned EffectWidth = 64;

   // interaction modes; the unused code runs as additive by additive
   localparam logic [1:0] MODE_AA = 2'd0;
   localparam logic [1:0] MODE_DD = 2'd1;
   localparam logic [1:0] MODE_AD = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_USE_PAIR  = 2'd2;

   localparam logic [16:0] OneQ16 = 17'd65536;

   localparam logic [1:0] GENO_ZERO  = 2'd0;
   localparam logic [1:0] GENO_THIRD = 2'd1;
   localparam logic [1:0] GENO_ONE   = 2'd2;
   localparam logic [1:0] GENO_TWO   = 2'd3;

   // Q16 dosage for a two-bit genotype code
   function automatic logic [17:0] dosage(input logic [1:0] code);
      logic [17:0] d;
      unique case (code)
         GENO_ZERO:  d = 18'd0;
         GENO_THIRD: d = 18'd21845;
         GENO_ONE:   d = 18'd65536;
         GENO_TWO:   d = 18'd131072;
         default:    d = 18'd0;
      endcase
      return d;
   endfunction

   typedef struct packed {
      logic load;
      logic het;
      logic prod;
      logic wgt;
      logic acc;
      logic cmp;
      logic emit_fwd;
      logic emit_rev;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic pass_fwd;
      logic pass_rev;
      logic out_free;
   } status_type;

endpackage

// File: rtl/epes_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epes_ctrl
// Sequencer: steps one word through the datapath stages, then on the last
// individual compares the sums and emits the passing effects.
// ----------------------------------------------------------------------------
module epes_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  epes_pkg::status_type status,
   output epes_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HET   = 8'b0000_0010,
      ST_PROD  = 8'b0000_0100,
      ST_WGT   = 8'b0000_1000,
      ST_ACC   = 8'b0001_0000,
      ST_CMP   = 8'b0010_0000,
      ST_EMITF = 8'b0100_0000,
      ST_EMITR = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HET;
            end
         end
         ST_HET: begin
            cmd.het  = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_WGT;
         end
         ST_WGT: begin
            cmd.wgt  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last ? ST_CMP : ST_IDLE;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_EMITF;
         end
         ST_EMITF: begin
            if (!status.pass_fwd || status.out_free) begin
               cmd.emit_fwd = status.pass_fwd;
               if (status.pass_rev) begin
                  state_in = ST_EMITR;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_EMITR: begin
            if (status.out_free) begin
               cmd.emit_rev = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/epes_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epes_dp
// Datapath: genotype decode, heterozygosity term, value product, weight
// product, saturating sums, cutoff compare and the result register.
// ----------------------------------------------------------------------------
module epes_dp #(
   parameter int unsigned MAX_MARKERS = epes_pkg::DefaultMaxMarkers
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  epes_pkg::cmd_type                    cmd,
   output epes_pkg::status_type                 status,
   input  logic [1:0]                           mode,
   input  logic [epes_pkg::ThrWidth-1:0]        effect_threshold,
   input  logic                                 use_pair_threshold,
   input  logic [1:0]                           req_first_code,
   input  logic [1:0]                           req_second_code,
   input  logic [epes_pkg::FreqWidth-1:0]       req_first_freq,
   input  logic [epes_pkg::FreqWidth-1:0]       req_second_freq,
   input  logic signed [epes_pkg::WeightWidth-1:0] req_weight,
   input  logic [epes_pkg::ThrWidth-1:0]        req_pair_threshold,
   input  logic [epes_pkg::SnpWidth-1:0]        req_first_snp,
   input  logic [epes_pkg::SnpWidth-1:0]        req_second_snp,
   input  logic                                 req_last_item,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [epes_pkg::SnpWidth-1:0]        rsp_row_snp,
   output logic [epes_pkg::SnpWidth-1:0]        rsp_col_snp,
   output logic signed [epes_pkg::EffectWidth-1:0] rsp_effect,
   output logic                                 rsp_last_result
);

   localparam logic [31:0] IdxTop = 32'(MAX_MARKERS - 1);
   localparam logic signed [63:0] SumMax = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SumMin = {1'b1, {63{1'b0}}};

   // captured word
   logic [1:0]          code1_ff, code2_ff;
   logic [16:0]         p1_ff, p2_ff;
   logic signed [31:0]  w_ff;
   logic [47:0]         pthr_ff;
   logic [15:0]         s1_ff, s2_ff;
   logic                last_ff;

   logic [15:0] s1_in, s2_in;
   logic [16:0] p1_in, p2_in;

   assign p1_in = (req_first_freq > epes_pkg::OneQ16) ? epes_pkg::OneQ16 : req_first_freq;
   assign p2_in = (req_second_freq > epes_pkg::OneQ16) ? epes_pkg::OneQ16 : req_second_freq;
   assign s1_in = ({16'd0, req_first_snp} > IdxTop) ? IdxTop[15:0] : req_first_snp;
   assign s2_in = ({16'd0, req_second_snp} > IdxTop) ? IdxTop[15:0] : req_second_snp;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code1_ff <= req_first_code;
         code2_ff <= req_second_code;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         w_ff     <= req_weight;
         pthr_ff  <= req_pair_threshold;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.load) begin
         last_ff <= req_last_item;
      end
   end

   // 2p(1-p), rounded to Q16
   logic [33:0] het_raw1, het_raw2;
   logic [35:0] het_sum1, het_sum2;
   logic [16:0] h1_ff, h2_ff;

   assign het_raw1 = p1_ff * (epes_pkg::OneQ16 - p1_ff);
   assign het_raw2 = p2_ff * (epes_pkg::OneQ16 - p2_ff);
   assign het_sum1 = {1'b0, het_raw1, 1'b0} + 36'd32768;
   assign het_sum2 = {1'b0, het_raw2, 1'b0} + 36'd32768;

   always_ff @(posedge clock) begin
      if (cmd.het) begin
         h1_ff <= het_sum1[32:16];
         h2_ff <= het_sum2[32:16];
      end
   end

   // additive and dominance values, then the value products
   logic [17:0]        dos1, dos2, dom1, dom2;
   logic signed [18:0] a1, a2, d1, d2, fx, fy;
   logic signed [37:0] prod_f_ff, prod_r_ff;

   assign dos1 = epes_pkg::dosage(code1_ff);
   assign dos2 = epes_pkg::dosage(code2_ff);
   assign dom1 = (code1_ff == epes_pkg::GENO_TWO) ? 18'd0 : dos1;
   assign dom2 = (code2_ff == epes_pkg::GENO_TWO) ? 18'd0 : dos2;
   assign a1 = $signed({1'b0, dos1}) - $signed({1'b0, p1_ff, 1'b0});
   assign a2 = $signed({1'b0, dos2}) - $signed({1'b0, p2_ff, 1'b0});
   assign d1 = $signed({1'b0, dom1}) - $signed({2'b0, h1_ff});
   assign d2 = $signed({1'b0, dom2}) - $signed({2'b0, h2_ff});

   always_comb begin
      case (mode)
         epes_pkg::MODE_DD: begin
            fx = d1;
            fy = d2;
         end
         epes_pkg::MODE_AD: begin
            fx = a1;
            fy = d2;
         end
         default: begin
            fx = a1;
            fy = a2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         prod_f_ff <= fx * fy;
         prod_r_ff <= d1 * a2;
      end
   end

   // round to Q16, times weight
   logic signed [38:0] pr_sum_f, pr_sum_r;
   logic signed [22:0] pr_f, pr_r;
   logic signed [54:0] wt_f_ff, wt_r_ff;

   assign pr_sum_f = {prod_f_ff[37], prod_f_ff} + 39'sd32768;
   assign pr_sum_r = {prod_r_ff[37], prod_r_ff} + 39'sd32768;
   assign pr_f = $signed(pr_sum_f[38:16]);
   assign pr_r = $signed(pr_sum_r[38:16]);

   always_ff @(posedge clock) begin
      if (cmd.wgt) begin
         wt_f_ff <= pr_f * w_ff;
         wt_r_ff <= pr_r * w_ff;
      end
   end

   // round again and add with saturation
   logic signed [55:0] ts_f, ts_r;
   logic signed [63:0] term_f, term_r, add_f, add_r, sat_f, sat_r;
   logic signed [63:0] sum_f_ff, sum_r_ff;

   assign ts_f   = {wt_f_ff[54], wt_f_ff} + 56'sd32768;
   assign ts_r   = {wt_r_ff[54], wt_r_ff} + 56'sd32768;
   assign term_f = {{24{ts_f[55]}}, ts_f[55:16]};
   assign term_r = {{24{ts_r[55]}}, ts_r[55:16]};
   assign add_f  = sum_f_ff + term_f;
   assign add_r  = sum_r_ff + term_r;

   always_comb begin
      sat_f = add_f;
      if ((sum_f_ff[63] == term_f[63]) && (add_f[63] != sum_f_ff[63])) begin
         sat_f = term_f[63] ? SumMin : SumMax;
      end
      sat_r = add_r;
      if ((sum_r_ff[63] == term_r[63]) && (add_r[63] != sum_r_ff[63])) begin
         sat_r = term_r[63] ? SumMin : SumMax;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sum_f_ff <= '0;
         sum_r_ff <= '0;
      end else if (cmd.acc) begin
         sum_f_ff <= sat_f;
         if (mode == epes_pkg::MODE_AD) begin
            sum_r_ff <= sat_r;
         end
      end
   end

   // cutoff compare on magnitude, strictly greater
   logic [47:0] thr;
   logic [63:0] mag_f, mag_r;
   logic        pass_f_ff, pass_r_ff;

   assign thr   = use_pair_threshold ? pthr_ff : effect_threshold;
   assign mag_f = sum_f_ff[63] ? (64'd0 - sum_f_ff) : sum_f_ff;
   assign mag_r = sum_r_ff[63] ? (64'd0 - sum_r_ff) : sum_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_f_ff <= 1'b0;
         pass_r_ff <= 1'b0;
      end else if (cmd.cmp) begin
         pass_f_ff <= (mag_f > {16'd0, thr});
         pass_r_ff <= (mode == epes_pkg::MODE_AD) && (mag_r > {16'd0, thr});
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic [15:0]        row_ff, col_ff;
   logic signed [63:0] effect_ff;
   logic               rlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_fwd || cmd.emit_rev) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fwd) begin
         row_ff    <= s1_ff;
         col_ff    <= s2_ff;
         effect_ff <= sum_f_ff;
         rlast_ff  <= !pass_r_ff;
      end else if (cmd.emit_rev) begin
         row_ff    <= s2_ff;
         col_ff    <= s1_ff;
         effect_ff <= sum_r_ff;
         rlast_ff  <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_snp     = row_ff;
   assign rsp_col_snp     = col_ff;
   assign rsp_effect      = effect_ff;
   assign rsp_last_result = rlast_ff;

   assign status.last     = last_ff;
   assign status.pass_fwd = pass_f_ff;
   assign status.pass_rev = pass_r_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/epistasis_pair_effect_scan_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epistasis_pair_effect_scan_top
// Accumulates weighted epistatic products over the individuals of one marker
// pair and emits the effects whose magnitude exceeds the cutoff.
// ----------------------------------------------------------------------------
// Words: one at a time; req_stall holds the next word off until the current one
// has passed load, 2p(1-p), value product, weight product and saturating add. A
// last word then also passes compare and forward emit, and reverse emit with a
// reverse result; a result waits while the output register stays stalled.
// Results: a pair's results enter the output register at the emit steps, forward first.
// Reset: synchronous; clears sums, registers (mode AA, cutoff 0) and control.
module epistasis_pair_effect_scan_top #(
   parameter int unsigned MAX_MARKERS = epes_pkg::DefaultMaxMarkers
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_first_code,
   input  logic [1:0]                           req_second_code,
   input  logic [epes_pkg::FreqWidth-1:0]       req_first_freq,
   input  logic [epes_pkg::FreqWidth-1:0]       req_second_freq,
   input  logic signed [epes_pkg::WeightWidth-1:0] req_weight,
   input  logic [epes_pkg::ThrWidth-1:0]        req_pair_threshold,
   input  logic [epes_pkg::SnpWidth-1:0]        req_first_snp,
   input  logic [epes_pkg::SnpWidth-1:0]        req_second_snp,
   input  logic                                 req_last_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [epes_pkg::SnpWidth-1:0]        rsp_row_snp,
   output logic [epes_pkg::SnpWidth-1:0]        rsp_col_snp,
   output logic signed [epes_pkg::EffectWidth-1:0] rsp_effect,
   output logic                                 rsp_last_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [epes_pkg::ThrWidth-1:0]        csr_wdata
);

   logic [1:0]  mode_ff;
   logic [47:0] thr_ff;
   logic        use_pair_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= epes_pkg::MODE_AA;
         thr_ff      <= '0;
         use_pair_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            epes_pkg::CSR_MODE:      mode_ff     <= csr_wdata[1:0];
            epes_pkg::CSR_THRESHOLD: thr_ff      <= csr_wdata;
            epes_pkg::CSR_USE_PAIR:  use_pair_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   epes_pkg::cmd_type    cmd;
   epes_pkg::status_type status;

   epes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   epes_dp #(
      .MAX_MARKERS (MAX_MARKERS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .mode               (mode_ff),
      .effect_threshold   (thr_ff),
      .use_pair_threshold (use_pair_ff),
      .req_first_code     (req_first_code),
      .req_second_code    (req_second_code),
      .req_first_freq     (req_first_freq),
      .req_second_freq    (req_second_freq),
      .req_weight         (req_weight),
      .req_pair_threshold (req_pair_threshold),
      .req_first_snp      (req_first_snp),
      .req_second_snp     (req_second_snp),
      .req_last_item      (req_last_item),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_row_snp        (rsp_row_snp),
      .rsp_col_snp        (rsp_col_snp),
      .rsp_effect         (rsp_effect),
      .rsp_last_result    (rsp_last_result)
   );

   // an accepted word holds off the next one while it is processed
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted on consecutive cycles");

   // only mode AD produces two results per pair
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mode_ff != epes_pkg::MODE_AD)) |-> rsp_last_result)
      else $error("non-final result outside AD mode");

   // a passing effect strictly exceeds a non-negative cutoff
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_effect != 64'sd0))
      else $error("zero effect emitted");

endmodule

// File: bench/tb_epistasis_pair_effect_scan_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epistasis_pair_effect_scan_top
// Self-checking bench for the pair effect scan. Individuals are streamed as
// marker pairs under every interaction mode and both cutoff sources. A local
// Q16 predictor accumulates the weighted products and queues the effects
// that should clear the cutoff. Every response word is checked in order
// against that queue, mostly while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_epistasis_pair_effect_scan_top;

   localparam logic [1:0] MODE_SPARE = 2'd3;  // unused mode code, runs as AA
   localparam logic [1:0] CSR_SPARE  = 2'd3;  // unused register index
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic [1:0]         first_code;
      logic [1:0]         second_code;
      logic [16:0]        first_freq;
      logic [16:0]        second_freq;
      logic signed [31:0] weight;
      logic [47:0]        pair_threshold;
      logic [15:0]        first_snp;
      logic [15:0]        second_snp;
      logic               last_item;
   } pair_word_type;

   typedef struct {
      logic [15:0] row_snp;
      logic [15:0] col_snp;
      longint      effect;
      logic        last_result;
   } effect_rec_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_first_code;
   logic [1:0]         req_second_code;
   logic [16:0]        req_first_freq;
   logic [16:0]        req_second_freq;
   logic signed [31:0] req_weight;
   logic [47:0]        req_pair_threshold;
   logic [15:0]        req_first_snp;
   logic [15:0]        req_second_snp;
   logic               req_last_item;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_row_snp;
   logic [15:0]        rsp_col_snp;
   logic signed [63:0] rsp_effect;
   logic               rsp_last_result;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [47:0]        csr_wdata;

   // predictor state
   logic [1:0]  mode_mirror = epes_pkg::MODE_AA;
   logic [47:0] cutoff_mirror = '0;
   logic        use_pair_mirror = 1'b0;
   longint      sum_fwd = 0;
   longint      sum_rev = 0;
   effect_rec_type pending_effects[$];

   int send_idle_pct = 27;
   int recv_idle_pct = 65;
   int mismatches = 0;

   epistasis_pair_effect_scan_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_code     (req_first_code),
      .req_second_code    (req_second_code),
      .req_first_freq     (req_first_freq),
      .req_second_freq    (req_second_freq),
      .req_weight         (req_weight),
      .req_pair_threshold (req_pair_threshold),
      .req_first_snp      (req_first_snp),
      .req_second_snp     (req_second_snp),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_row_snp        (rsp_row_snp),
      .rsp_col_snp        (rsp_col_snp),
      .rsp_effect         (rsp_effect),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------- Q16 effect predictor ----------------

   function automatic longint dose_of(logic [1:0] code);
      case (code)
         epes_pkg::GENO_THIRD: return 21845;
         epes_pkg::GENO_ONE:   return 65536;
         epes_pkg::GENO_TWO:   return 131072;
         default:              return 0;
      endcase
   endfunction

   function automatic longint freq_of(logic [16:0] f);
      return (f > epes_pkg::OneQ16) ? 65536 : longint'(f);
   endfunction

   function automatic longint add_value(logic [1:0] code, longint p);
      return dose_of(code) - 2 * p;
   endfunction

   function automatic longint dom_value(logic [1:0] code, longint p);
      longint d;
      longint het;
      d = (code == epes_pkg::GENO_TWO) ? 0 : dose_of(code);
      het = (2 * p * (65536 - p) + 32768) >>> 16;
      return d - het;
   endfunction

   function automatic longint q16_round(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint effect_term(longint a, longint b, longint w);
      return q16_round(q16_round(a * b) * w);
   endfunction

   function automatic longint sat_add64(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7fff_ffff_ffff_ffff;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
   endfunction

   function automatic logic [63:0] magnitude_of(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   task automatic accumulate_effects(input pair_word_type w);
      longint p1, p2, wt;
      logic [63:0] cut;
      bit fwd_ok, rev_ok;
      p1 = freq_of(w.first_freq);
      p2 = freq_of(w.second_freq);
      wt = longint'(w.weight);
      case (mode_mirror)
         epes_pkg::MODE_DD: begin
            sum_fwd = sat_add64(sum_fwd, effect_term(dom_value(w.first_code, p1),
                                                     dom_value(w.second_code, p2), wt));
         end
         epes_pkg::MODE_AD: begin
            sum_fwd = sat_add64(sum_fwd, effect_term(add_value(w.first_code, p1),
                                                     dom_value(w.second_code, p2), wt));
            sum_rev = sat_add64(sum_rev, effect_term(dom_value(w.first_code, p1),
                                                     add_value(w.second_code, p2), wt));
         end
         default: begin
            sum_fwd = sat_add64(sum_fwd, effect_term(add_value(w.first_code, p1),
                                                     add_value(w.second_code, p2), wt));
         end
      endcase
      if (w.last_item) begin
         cut = {16'd0, use_pair_mirror ? w.pair_threshold : cutoff_mirror};
         fwd_ok = magnitude_of(sum_fwd) > cut;
         rev_ok = (mode_mirror == epes_pkg::MODE_AD) && (magnitude_of(sum_rev) > cut);
         if (fwd_ok)
            pending_effects.push_back('{w.first_snp, w.second_snp, sum_fwd, !rev_ok});
         if (rev_ok)
            pending_effects.push_back('{w.second_snp, w.first_snp, sum_rev, 1'b1});
         sum_fwd = 0;
         sum_rev = 0;
      end
   endtask

   // ---------------- response checker ----------------

   always @(posedge clock) begin
      effect_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_effects.size() == 0) begin
            $error("unexpected rsp word: row_snp %0d col_snp %0d effect %0d",
                   rsp_row_snp, rsp_col_snp, rsp_effect);
            mismatches++;
         end else begin
            want = pending_effects.pop_front();
            if (rsp_row_snp !== want.row_snp) begin
               $error("row_snp expected %0d got %0d", want.row_snp, rsp_row_snp);
               mismatches++;
            end
            if (rsp_col_snp !== want.col_snp) begin
               $error("col_snp expected %0d got %0d", want.col_snp, rsp_col_snp);
               mismatches++;
            end
            if (rsp_effect !== want.effect) begin
               $error("effect expected %0d got %0d", want.effect, rsp_effect);
               mismatches++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result expected %0d got %0d", want.last_result,
                      rsp_last_result);
               mismatches++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ---------------- drivers ----------------

   task automatic send_word(input pair_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_first_code     <= w.first_code;
      req_second_code    <= w.second_code;
      req_first_freq     <= w.first_freq;
      req_second_freq    <= w.second_freq;
      req_weight         <= w.weight;
      req_pair_threshold <= w.pair_threshold;
      req_first_snp      <= w.first_snp;
      req_second_snp     <= w.second_snp;
      req_last_item      <= w.last_item;
      do @(posedge clock); while (req_stall);
      accumulate_effects(w);
   endtask

   // holds the sender off until every queued effect is out and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_effects.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         epes_pkg::CSR_MODE:      mode_mirror = data[1:0];
         epes_pkg::CSR_THRESHOLD: cutoff_mirror = data;
         epes_pkg::CSR_USE_PAIR:  use_pair_mirror = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic pair_word_type make_word(
      logic [1:0] c1, logic [1:0] c2, logic [16:0] f1, logic [16:0] f2,
      logic signed [31:0] wt, logic [47:0] pthr, logic [15:0] s1, logic [15:0] s2,
      logic last);
      pair_word_type w;
      w = '{c1, c2, f1, f2, wt, pthr, s1, s2, last};
      return w;
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   function automatic logic [47:0] pick_cutoff();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return rand48() >> $urandom_range(0, 47);
      endcase
   endfunction

   function automatic logic [16:0] pick_freq();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return epes_pkg::OneQ16;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         3, 4, 5: return 32'($urandom_range(0, 2097152)) - 32'sd1048576;
         default: return 32'($urandom);
      endcase
   endfunction

   // ---------------- tests ----------------

   // registers still at reset: mode AA, global cutoff zero
   task automatic test_reset_defaults();
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_TWO, '0, '0, 32'sd65536,
                          rand48(), 16'd7, 16'd9, 1'b1));
      drain();
   endtask

   task automatic test_additive_codes();
      send_word(make_word(epes_pkg::GENO_ZERO, epes_pkg::GENO_THIRD, '0,
                          epes_pkg::OneQ16, 32'sh7fff_ffff, '1,
                          16'd100, 16'd200, 1'b0));
      send_word(make_word(epes_pkg::GENO_THIRD, epes_pkg::GENO_ONE, 17'd131071,
                          17'd32768, 32'sh8000_0000, '0, 16'd300, 16'd400, 1'b0));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_TWO, 17'd1, 17'd65535,
                          -32'sd1, rand48(), 16'd500, 16'd600, 1'b0));
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_ZERO, 17'd65537,
                          17'd12345, 32'sd0, '1, 16'd0, 16'hffff, 1'b1));
      // zero sum never clears a zero cutoff
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_TWO, '0, '0, 32'sd0, '0,
                          16'hffff, 16'd0, 1'b1));
      drain();
   endtask

   // effect of exactly one (65536): equal cutoff must not pass
   task automatic test_cutoff_edges();
      csr_write(epes_pkg::CSR_USE_PAIR, 48'd1);
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_ONE, '0, '0, 32'sd65536,
                          48'd65536, 16'd11, 16'd12, 1'b1));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_ONE, '0, '0, 32'sd65536,
                          48'd65535, 16'd13, 16'd14, 1'b1));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_ONE, '0, '0, -32'sd65536,
                          48'd65535, 16'd15, 16'd16, 1'b1));
      drain();
      csr_write(epes_pkg::CSR_USE_PAIR, 48'd0);
      csr_write(epes_pkg::CSR_THRESHOLD, '1);
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_TWO, '0, '0, 32'sh7fff_ffff,
                          '0, 16'd17, 16'd18, 1'b1));
      drain();
      csr_write(epes_pkg::CSR_THRESHOLD, 48'd65535);
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_ONE, '0, '0, 32'sd65536,
                          '1, 16'd19, 16'd20, 1'b1));
      drain();
   endtask

   task automatic test_dominance();
      csr_write(epes_pkg::CSR_MODE, {46'd0, epes_pkg::MODE_DD});
      csr_write(epes_pkg::CSR_THRESHOLD, 48'd0);
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_TWO, 17'd32768,
                          epes_pkg::OneQ16, pick_weight(), '0, 16'd1, 16'd2, 1'b0));
      send_word(make_word(epes_pkg::GENO_ZERO, epes_pkg::GENO_THIRD, 17'd131071, '0,
                          pick_weight(), '0, 16'd1, 16'd2, 1'b0));
      send_word(make_word(epes_pkg::GENO_THIRD, epes_pkg::GENO_ONE, 17'd1, 17'd65535,
                          pick_weight(), '0, 16'd1, 16'd2, 1'b0));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_ZERO, epes_pkg::OneQ16,
                          17'd32768, pick_weight(), '0, 16'd1, 16'd2, 1'b1));
      drain();
   endtask

   task automatic test_additive_dominance();
      csr_write(epes_pkg::CSR_MODE, {46'd0, epes_pkg::MODE_AD});
      // dominance of a two-dosage code is zero, so only one order survives
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_ONE, '0, '0, 32'sd65536,
                          '0, 16'd21, 16'd22, 1'b1));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_TWO, '0, '0, 32'sd65536,
                          '0, 16'd23, 16'd24, 1'b1));
      send_word(make_word(epes_pkg::GENO_THIRD, epes_pkg::GENO_ONE, 17'd16384,
                          17'd49152, 32'sh7fff_ffff, '0, 16'd25, 16'd26, 1'b0));
      send_word(make_word(epes_pkg::GENO_ONE, epes_pkg::GENO_THIRD, 17'd16384,
                          17'd49152, 32'sh8000_0000, '0, 16'hfffe, 16'd1, 1'b1));
      drain();
   endtask

   task automatic test_spare_mode();
      csr_write(epes_pkg::CSR_MODE, {46'd0, MODE_SPARE});
      csr_write(CSR_SPARE, rand48());
      send_word(make_word(epes_pkg::GENO_THIRD, epes_pkg::GENO_TWO, 17'd40000,
                          17'd70000, pick_weight(), '0, 16'd31, 16'd32, 1'b0));
      send_word(make_word(epes_pkg::GENO_TWO, epes_pkg::GENO_THIRD, 17'd40000,
                          17'd70000, pick_weight(), '0, 16'd31, 16'd32, 1'b1));
      drain();
   endtask

   task automatic test_random_pairs();
      int seg, words, len, k;
      pair_word_type w;
      logic [47:0] r;
      logic [16:0] f1, f2;
      logic [15:0] s1, s2;
      bit steady;
      for (seg = 0; seg < 12; seg++) begin
         if (seg == 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 27;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         r = rand48();
         r[1:0] = 2'(seg % 4);
         csr_write(epes_pkg::CSR_MODE, r);
         csr_write(epes_pkg::CSR_THRESHOLD, pick_cutoff());
         r = rand48();
         r[0] = seg[1];
         csr_write(epes_pkg::CSR_USE_PAIR, r);
         if ($urandom_range(0, 3) == 0) csr_write(CSR_SPARE, rand48());
         words = 0;
         while (words < 115) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 40);
            f1 = pick_freq();
            f2 = pick_freq();
            s1 = 16'($urandom);
            s2 = 16'($urandom);
            steady = ($urandom_range(0, 9) != 0);
            for (k = 0; k < len; k++) begin
               w.first_code     = 2'($urandom);
               w.second_code    = 2'($urandom);
               w.first_freq     = steady ? f1 : pick_freq();
               w.second_freq    = steady ? f2 : pick_freq();
               w.weight         = pick_weight();
               w.pair_threshold = pick_cutoff();
               w.last_item      = (k == len - 1);
               // marker ids only matter on the closing word
               w.first_snp  = (w.last_item || $urandom_range(0, 4) != 0) ? s1
                                                                         : 16'($urandom);
               w.second_snp = (w.last_item || $urandom_range(0, 4) != 0) ? s2
                                                                         : 16'($urandom);
               send_word(w);
            end
            words += len;
         end
      end
      drain();
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_first_code     <= '0;
      req_second_code    <= '0;
      req_first_freq     <= '0;
      req_second_freq    <= '0;
      req_weight         <= '0;
      req_pair_threshold <= '0;
      req_first_snp      <= '0;
      req_second_snp     <= '0;
      req_last_item      <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= epes_pkg::CSR_MODE;
      csr_wdata          <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_additive_codes();
      test_cutoff_edges();
      test_dominance();
      test_additive_dominance();
      test_spare_mode();
      test_random_pairs();

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/epes_pkg.sv
rtl/epes_ctrl.sv
rtl/epes_dp.sv
rtl/epistasis_pair_effect_scan_top.sv
bench/tb_epistasis_pair_effect_scan_top.sv
